>>> hdl/sbpo_pkg.sv
// Shared widths and types for the box pair overlap pipeline.
`default_nettype none
package sbpo_pkg;
    localparam int CoordW = 16;
    localparam int HalfW  = 14;
    localparam int TrigW  = 16;
    localparam int FracW  = 14;
    localparam int ProdW  = HalfW + 1 + TrigW;
    localparam int TermW  = ProdW - FracW;
    localparam int CornW  = 18;
    localparam int NormW  = CornW + 1;
    localparam int ProjW  = 40;
    localparam int NumCorners = 4;
    localparam int NumAxes    = 4;
    localparam int Depth      = 6;

    typedef logic signed [CornW-1:0] corner_t;

    typedef struct packed {
        corner_t [NumCorners-1:0] x;
        corner_t [NumCorners-1:0] y;
    } corners_t;
endpackage
`default_nettype wire

>>> hdl/sbpo_if.sv
// Request and result channel interfaces.
`default_nettype none
interface sbpo_req_if;
    logic valid;
    logic ready;
    logic signed [15:0] a_center_x;
    logic signed [15:0] a_center_y;
    logic [13:0] a_half_width;
    logic [13:0] a_half_height;
    logic signed [15:0] a_cos;
    logic signed [15:0] a_sin;
    logic signed [15:0] b_center_x;
    logic signed [15:0] b_center_y;
    logic [13:0] b_half_width;
    logic [13:0] b_half_height;
    logic signed [15:0] b_cos;
    logic signed [15:0] b_sin;
    modport source (output valid, a_center_x, a_center_y, a_half_width, a_half_height,
                    a_cos, a_sin, b_center_x, b_center_y, b_half_width, b_half_height,
                    b_cos, b_sin, input ready);
    modport sink (input valid, a_center_x, a_center_y, a_half_width, a_half_height,
                  a_cos, a_sin, b_center_x, b_center_y, b_half_width, b_half_height,
                  b_cos, b_sin, output ready);
endinterface

interface sbpo_rsp_if;
    logic valid;
    logic ready;
    logic overlapping;
    modport source (output valid, overlapping, input ready);
    modport sink (input valid, overlapping, output ready);
endinterface
`default_nettype wire

>>> hdl/sbpo_box.sv
// Two-stage corner generator for one rotated box.
`default_nettype none
module sbpo_box (
    input  wire logic                                clk,
    input  wire logic                                en,
    input  wire logic signed [sbpo_pkg::CoordW-1:0]  cx,
    input  wire logic signed [sbpo_pkg::CoordW-1:0]  cy,
    input  wire logic        [sbpo_pkg::HalfW-1:0]   hw,
    input  wire logic        [sbpo_pkg::HalfW-1:0]   hh,
    input  wire logic signed [sbpo_pkg::TrigW-1:0]   c,
    input  wire logic signed [sbpo_pkg::TrigW-1:0]   s,
    output sbpo_pkg::corners_t                       corners
);
    logic signed [sbpo_pkg::ProdW-1:0] p_ws, p_wc, p_hc, p_hs;
    logic signed [sbpo_pkg::TermW-1:0] ws_reg, wc_reg, hc_reg, hs_reg;
    logic signed [sbpo_pkg::CoordW-1:0] cx_reg, cy_reg;
    logic signed [sbpo_pkg::CornW-1:0] px, py, ws, wc, hc, hs;
    sbpo_pkg::corners_t corners_next, corners_reg;

    assign p_ws = $signed({1'b0, hw}) * s;
    assign p_wc = $signed({1'b0, hw}) * c;
    assign p_hc = $signed({1'b0, hh}) * c;
    assign p_hs = $signed({1'b0, hh}) * s;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // floor by dropping fraction bits
            ws_reg <= p_ws[sbpo_pkg::ProdW-1:sbpo_pkg::FracW];
            wc_reg <= p_wc[sbpo_pkg::ProdW-1:sbpo_pkg::FracW];
            hc_reg <= p_hc[sbpo_pkg::ProdW-1:sbpo_pkg::FracW];
            hs_reg <= p_hs[sbpo_pkg::ProdW-1:sbpo_pkg::FracW];
            cx_reg <= cx;
            cy_reg <= cy;
            corners_reg <= corners_next;
        end
    end

    always_comb
    begin
        px = sbpo_pkg::CornW'(cx_reg);
        py = sbpo_pkg::CornW'(cy_reg);
        ws = sbpo_pkg::CornW'(ws_reg);
        wc = sbpo_pkg::CornW'(wc_reg);
        hc = sbpo_pkg::CornW'(hc_reg);
        hs = sbpo_pkg::CornW'(hs_reg);
        corners_next.x[0] = px - ws + wc;
        corners_next.y[0] = py + hc + hs;
        corners_next.x[1] = px + ws + wc;
        corners_next.y[1] = py - hc + hs;
        corners_next.x[2] = px + ws - wc;
        corners_next.y[2] = py - hc - hs;
        corners_next.x[3] = px - ws - wc;
        corners_next.y[3] = py + hc - hs;
    end

    assign corners = corners_reg;
endmodule
`default_nettype wire

>>> hdl/sat_box_pair_overlap_core.sv
// Separating axis overlap test for two rotated boxes, six-stage pipeline.
// Throughput: one pair per cycle; the whole pipe holds when the result stalls.
// Stages: products, corners, edge normals, projections, min/max, axis compare.
// Reset clears only the stage valid bits; payload registers are not reset.
`default_nettype none
module sat_box_pair_overlap_core (
    input wire logic clk,
    input wire logic rst_n,
    sbpo_req_if.sink   req,
    sbpo_rsp_if.source rsp
);
    localparam int NC = sbpo_pkg::NumCorners;
    localparam int NA = sbpo_pkg::NumAxes;

    logic [sbpo_pkg::Depth-1:0] v_reg, v_next;
    logic adv;

    sbpo_pkg::corners_t ca, cb, ca3_reg, cb3_reg;
    logic signed [sbpo_pkg::NormW-1:0] nx_next [NA], ny_next [NA];
    logic signed [sbpo_pkg::NormW-1:0] nx_reg [NA], ny_reg [NA];
    logic signed [sbpo_pkg::CornW-1:0] xs [2][NC], ys [2][NC];
    logic signed [sbpo_pkg::ProjW-1:0] pr_next [NA][2][NC], pr_reg [NA][2][NC];
    logic signed [sbpo_pkg::ProjW-1:0] lo_next [NA][2], hi_next [NA][2];
    logic signed [sbpo_pkg::ProjW-1:0] lo_reg [NA][2], hi_reg [NA][2];
    logic ov_next, ov_reg;

    assign adv       = !v_reg[sbpo_pkg::Depth-1] || rsp.ready;
    assign req.ready = adv;
    assign v_next    = {v_reg[sbpo_pkg::Depth-2:0], req.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= v_next;
        end
    end

    sbpo_box u_box_a (
        .clk(clk), .en(adv),
        .cx(req.a_center_x), .cy(req.a_center_y),
        .hw(req.a_half_width), .hh(req.a_half_height),
        .c(req.a_cos), .s(req.a_sin), .corners(ca)
    );

    sbpo_box u_box_b (
        .clk(clk), .en(adv),
        .cx(req.b_center_x), .cy(req.b_center_y),
        .hw(req.b_half_width), .hh(req.b_half_height),
        .c(req.b_cos), .s(req.b_sin), .corners(cb)
    );

    // opposite edges give negated axes with the same verdict: two axes per box
    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            nx_next[k]   = sbpo_pkg::NormW'($signed(ca.y[k]))
                         - sbpo_pkg::NormW'($signed(ca.y[k+1]));
            ny_next[k]   = sbpo_pkg::NormW'($signed(ca.x[k+1]))
                         - sbpo_pkg::NormW'($signed(ca.x[k]));
            nx_next[k+2] = sbpo_pkg::NormW'($signed(cb.y[k]))
                         - sbpo_pkg::NormW'($signed(cb.y[k+1]));
            ny_next[k+2] = sbpo_pkg::NormW'($signed(cb.x[k+1]))
                         - sbpo_pkg::NormW'($signed(cb.x[k]));
        end
    end

    always_comb
    begin
        for (int k = 0; k < NC; k++)
        begin
            xs[0][k] = $signed(ca3_reg.x[k]);
            ys[0][k] = $signed(ca3_reg.y[k]);
            xs[1][k] = $signed(cb3_reg.x[k]);
            ys[1][k] = $signed(cb3_reg.y[k]);
        end
        for (int j = 0; j < NA; j++)
        begin
            for (int b = 0; b < 2; b++)
            begin
                for (int k = 0; k < NC; k++)
                begin
                    pr_next[j][b][k] = sbpo_pkg::ProjW'(xs[b][k]) * sbpo_pkg::ProjW'(nx_reg[j])
                                     + sbpo_pkg::ProjW'(ys[b][k]) * sbpo_pkg::ProjW'(ny_reg[j]);
                end
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < NA; j++)
        begin
            for (int b = 0; b < 2; b++)
            begin
                lo_next[j][b] = pr_reg[j][b][0];
                hi_next[j][b] = pr_reg[j][b][0];
                for (int k = 1; k < NC; k++)
                begin
                    if (pr_reg[j][b][k] < lo_next[j][b])
                    begin
                        lo_next[j][b] = pr_reg[j][b][k];
                    end
                    if (pr_reg[j][b][k] > hi_next[j][b])
                    begin
                        hi_next[j][b] = pr_reg[j][b][k];
                    end
                end
            end
        end
    end

    always_comb
    begin
        ov_next = 1'b1;
        for (int j = 0; j < NA; j++)
        begin
            if (!(hi_reg[j][1] > lo_reg[j][0] && hi_reg[j][0] > lo_reg[j][1]))
            begin
                ov_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ca3_reg <= ca;
            cb3_reg <= cb;
            nx_reg  <= nx_next;
            ny_reg  <= ny_next;
            pr_reg  <= pr_next;
            lo_reg  <= lo_next;
            hi_reg  <= hi_next;
            ov_reg  <= ov_next;
        end
    end

    assign rsp.valid       = v_reg[sbpo_pkg::Depth-1];
    assign rsp.overlapping = ov_reg;

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> v_reg[0])
        else $error("accepted beat did not enter the pipe");
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(v_reg))
        else $error("pipe moved while stalled");
    a_last_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && v_reg[sbpo_pkg::Depth-2]) |=> rsp.valid)
        else $error("beat lost before output");
endmodule
`default_nettype wire

>>> tb/tb_overlap_sb.sv
// Overlap predictor and result store for the box pair overlap testbench.
`timescale 1ns / 1ps
class overlap_sb;
    bit pending[$];
    int mismatches;
    int checked;

    static function longint trunc14(longint v);
        return v >>> 14;
    endfunction

    static function void corners(input logic [15:0] cx, input logic [15:0] cy,
                                 input logic [13:0] hw, input logic [13:0] hh,
                                 input logic [15:0] c, input logic [15:0] s,
                                 output longint xs[4], output longint ys[4]);
        longint px, py, w, h, cc, ss, ws, wc, hc, hs;
        px = longint'($signed(cx));
        py = longint'($signed(cy));
        w = longint'(hw);
        h = longint'(hh);
        cc = longint'($signed(c));
        ss = longint'($signed(s));
        ws = trunc14(w * ss);
        wc = trunc14(w * cc);
        hc = trunc14(h * cc);
        hs = trunc14(h * ss);
        xs[0] = px - ws + wc; ys[0] = py + hc + hs;
        xs[1] = px + ws + wc; ys[1] = py - hc + hs;
        xs[2] = px + ws - wc; ys[2] = py - hc - hs;
        xs[3] = px - ws - wc; ys[3] = py + hc - hs;
    endfunction

    static function bit axes_clear(longint ex[4], longint ey[4], longint ax[4],
                                   longint ay[4], longint bx[4], longint by[4]);
        longint nx, ny, p, alo, ahi, blo, bhi;
        for (int k = 0; k < 4; k++)
        begin
            nx = -(ey[(k + 1) % 4] - ey[k]);
            ny = ex[(k + 1) % 4] - ex[k];
            alo = ax[0] * nx + ay[0] * ny;
            ahi = alo;
            blo = bx[0] * nx + by[0] * ny;
            bhi = blo;
            for (int j = 1; j < 4; j++)
            begin
                p = ax[j] * nx + ay[j] * ny;
                if (p < alo) alo = p;
                if (p > ahi) ahi = p;
                p = bx[j] * nx + by[j] * ny;
                if (p < blo) blo = p;
                if (p > bhi) bhi = p;
            end
            if (!(bhi > alo && ahi > blo))
                return 0;
        end
        return 1;
    endfunction

    function void note_pair(logic [15:0] acx, logic [15:0] acy, logic [13:0] ahw,
                            logic [13:0] ahh, logic [15:0] ac, logic [15:0] as_,
                            logic [15:0] bcx, logic [15:0] bcy, logic [13:0] bhw,
                            logic [13:0] bhh, logic [15:0] bc, logic [15:0] bs);
        longint ax[4], ay[4], bx[4], by[4];
        bit hit;
        corners(acx, acy, ahw, ahh, ac, as_, ax, ay);
        corners(bcx, bcy, bhw, bhh, bc, bs, bx, by);
        hit = axes_clear(ax, ay, ax, ay, bx, by) && axes_clear(bx, by, ax, ay, bx, by);
        pending = {pending, hit};
    endfunction

    function void check_overlap(logic got);
        bit want;
        checked++;
        if (pending.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result beat: overlapping=%0b", got);
            return;
        end
        want = pending.pop_front();
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch at beat %0d: expected %0b actual %0b",
                         checked - 1, want, got);
        end
    endfunction
endclass

>>> tb/tb_top.sv
// Top of the box pair overlap testbench: clock, reset, stimulus and checks.
`timescale 1ns / 1ps
module tb_top;
    logic clk;
    logic rst_n;
    int hold_off;
    int sent;
    bit stim_done;
    bit long_done;
    overlap_sb sb;

    sbpo_req_if req ();
    sbpo_rsp_if rsp ();

    sat_box_pair_overlap_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req.sink),
        .rsp(rsp.source)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [15:0] pick_coord(bit wild);
        case ($urandom_range(0, 5))
            0: return wild ? 16'h8000 : 16'h7FFF;
            1: return 16'($urandom);
            default: return 16'($signed($urandom_range(0, 8000)) - 4000);
        endcase
    endfunction

    function automatic logic [13:0] pick_half();
        case ($urandom_range(0, 9))
            0: return 14'd0;
            1: return 14'd8192;
            2: return 14'($urandom);
            default: return 14'($urandom_range(1, 3000));
        endcase
    endfunction

    task automatic pick_trig(output logic [15:0] c, output logic [15:0] s);
        real ang;
        if ($urandom_range(0, 7) == 0)
        begin
            c = 16'($urandom);
            s = 16'($urandom);
        end
        else
        begin
            ang = $urandom_range(0, 6283) / 1000.0;
            c = 16'($rtoi($cos(ang) * 16384.0));
            s = 16'($rtoi($sin(ang) * 16384.0));
        end
    endtask

    task automatic send_pair(logic [15:0] acx, logic [15:0] acy, logic [13:0] ahw,
                             logic [13:0] ahh, logic [15:0] ac, logic [15:0] as_,
                             logic [15:0] bcx, logic [15:0] bcy, logic [13:0] bhw,
                             logic [13:0] bhh, logic [15:0] bc, logic [15:0] bs);
        req.valid <= 1'b1;
        req.a_center_x <= acx;
        req.a_center_y <= acy;
        req.a_half_width <= ahw;
        req.a_half_height <= ahh;
        req.a_cos <= ac;
        req.a_sin <= as_;
        req.b_center_x <= bcx;
        req.b_center_y <= bcy;
        req.b_half_width <= bhw;
        req.b_half_height <= bhh;
        req.b_cos <= bc;
        req.b_sin <= bs;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        sb.note_pair(acx, acy, ahw, ahh, ac, as_, bcx, bcy, bhw, bhh, bc, bs);
        sent++;
    endtask

    task automatic send_random(bit near);
        logic [15:0] acx, acy, ac, as_, bcx, bcy, bc, bs;
        logic [13:0] ahw, ahh, bhw, bhh;
        acx = pick_coord($urandom_range(0, 1));
        acy = pick_coord($urandom_range(0, 1));
        ahw = pick_half();
        ahh = pick_half();
        bhw = pick_half();
        bhh = pick_half();
        if ($urandom_range(0, 3) != 0)
            ahh = ahw;
        if ($urandom_range(0, 3) != 0)
            bhh = bhw;
        pick_trig(ac, as_);
        pick_trig(bc, bs);
        if (near)
        begin
            bcx = acx + 16'($signed($urandom_range(0, 8000)) - 4000);
            bcy = acy + 16'($signed($urandom_range(0, 8000)) - 4000);
        end
        else
        begin
            bcx = pick_coord($urandom_range(0, 1));
            bcy = pick_coord($urandom_range(0, 1));
        end
        send_pair(acx, acy, ahw, ahh, ac, as_, bcx, bcy, bhw, bhh, bc, bs);
    endtask

    task automatic idle_gap();
        req.valid <= 1'b0;
        repeat ($urandom_range(1, 6))
            @(posedge clk);
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        req.valid <= 1'b0;
        {req.a_center_x, req.a_center_y, req.a_half_width, req.a_half_height,
         req.a_cos, req.a_sin, req.b_center_x, req.b_center_y, req.b_half_width,
         req.b_half_height, req.b_cos, req.b_sin} <= '0;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: aligned overlap, touching, separated, zero size, extremes
        send_pair(0, 0, 1024, 1024, 16384, 0, 0, 0, 1024, 1024, 16384, 0);
        send_pair(0, 0, 1024, 1024, 16384, 0, 2048, 0, 1024, 1024, 16384, 0);
        send_pair(0, 0, 1024, 1024, 16384, 0, 2047, 0, 1024, 1024, 16384, 0);
        send_pair(0, 0, 1024, 1024, 16384, 0, 5000, 5000, 1024, 1024, 16384, 0);
        send_pair(0, 0, 0, 1024, 16384, 0, 0, 0, 1024, 1024, 16384, 0);
        send_pair(0, 0, 1024, 1024, 11585, 11585, 100, 100, 1024, 1024, 0, 16384);
        send_pair(16'h7FFF, 16'h7FFF, 8192, 8192, 16'h8000, 16'h8000,
                  16'h8000, 16'h8000, 8192, 8192, 16'h7FFF, 16'h7FFF);
        send_pair(16'h8000, 16'h7FFF, 14'h3FFF, 14'h3FFF, 16'hFFFF, 16'h7FFF,
                  16'h7FFF, 16'h8000, 14'h3FFF, 14'h3FFF, 16'h8000, 16'hFFFF);
        send_pair(0, 0, 2000, 500, 16384, 0, 100, 0, 500, 2000, 0, 16384);
        send_pair(0, 0, 1000, 1000, 16'hC000, 16'hC000, 0, 0, 1000, 1000, -16384, 0);
        send_pair(16'hFFFF, 16'hFFFF, 1, 1, 16384, 16384, 16'hFFFF, 16'hFFFF, 1, 1,
                  16384, 16384);
        send_pair(0, 0, 14'h2AAA, 14'h1555, 16'h5555, 16'hAAAA, 0, 0, 14'h1555,
                  14'h2AAA, 16'hAAAA, 16'h5555);
        idle_gap();
        while (sent < 660)
        begin
            repeat ($urandom_range(1, 20))
                send_random($urandom_range(0, 9) < 7);
            if ($urandom_range(0, 2) != 0)
                idle_gap();
        end
        req.valid <= 1'b0;
        stim_done = 1'b1;
    end

    // receiver: random stall pattern, plus long hold-offs
    initial
    begin
        rsp.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off > 0)
            begin
                hold_off--;
                rsp.ready <= 1'b0;
            end
            else if (sent >= 40 && !long_done)
            begin
                long_done = 1'b1;
                hold_off = 40;
                rsp.ready <= 1'b0;
            end
            else if ($urandom_range(0, 299) == 0)
            begin
                hold_off = $urandom_range(20, 60);
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= ((sent / 100) % 2 == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge clk)
        if (rst_n && rsp.valid && rsp.ready)
            sb.check_overlap(rsp.overlapping);

    initial
    begin
        wait (stim_done);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (20)
            @(posedge clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("FAILURE");
        $finish;
    end
endmodule
